// ===== design/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyed session table
// Command codes, beat layouts and the result record handed between modules.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned CODE_W     = 31;
  localparam int unsigned ADDED_W    = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned ID_SPACE   = 1024;

  localparam logic [CMD_W-1:0] CMD_LOGIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOGOUT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  localparam logic [ADDED_W-1:0] ABSENT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               valid;
    logic [ADDED_W-1:0] added;
  } kst_res_t;

endpackage

// ===== design/kst_accum.sv =====
// ----------------------------------------------------------------------------
// kst_accum: running sum and output register
// Adds each finished value to the 64-bit wrapping sum and holds the result
// beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module kst_accum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kst_pkg::kst_res_t                   res,
  output logic                                res_ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kst_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import kst_pkg::*;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [ADDED_W-1:0] added_r;
  logic               out_valid_r;

  assign res_ready = !out_valid_r || out_tready;
  assign sum_nxt   = sum_r + {{(SUM_W-ADDED_W){res.added[ADDED_W-1]}}, res.added};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res.valid && res_ready) begin
        sum_r       <= sum_nxt;
        added_r     <= res.added;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sum_r, added_r};

endmodule

// ===== design/kst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kst_ctrl: table sequencer
// Holds the code table, the list of present ids and their positions, and
// steps each command through reads, updates and the list walk of close.
// ----------------------------------------------------------------------------
module kst_ctrl #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kst_pkg::IN_DATA_W-1:0]     in_tdata,
  output kst_pkg::kst_res_t                 res,
  input  logic                              res_ready
);
  import kst_pkg::*;

  localparam int unsigned DEPTH = (ENTRIES < ID_SPACE) ? ENTRIES : ID_SPACE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [ID_W:0]   ID_LIMIT = (ID_W+1)'(DEPTH);
  localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_CLOSE = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [AW-1:0]      id_r, id_nxt;
  logic               vid_r, vid_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDED_W-1:0] added_r, added_nxt;

  logic [ADDED_W-1:0] tbl_mem [DEPTH];
  logic [AW-1:0]      lst_mem [DEPTH];
  logic [AW-1:0]      pos_mem [DEPTH];
  logic [ADDED_W-1:0] tbl_q, tbl_wd;
  logic [AW-1:0]      lst_q, pos_q, lst_wd, pos_wd;
  logic [AW-1:0]      tbl_wa, lst_wa, pos_wa, lst_ra;
  logic               tbl_we, lst_we, pos_we;

  logic [CMD_W-1:0]   in_cmd;
  logic [ID_W-1:0]    in_id;
  logic [CODE_W-1:0]  in_code;
  logic [CW-1:0]      cnt_dec;
  logic               present;

  assign in_cmd  = in_tdata[CMD_W-1:0];
  assign in_id   = in_tdata[CMD_W+ID_W-1:CMD_W];
  assign in_code = in_tdata[CMD_W+ID_W+CODE_W-1:CMD_W+ID_W];
  assign cnt_dec = count_r - 1'b1;
  assign present = tbl_q != ABSENT;

  assign in_tready = state_r == ST_IDLE;
  assign res       = {state_r == ST_RES, added_r};

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    vid_nxt   = vid_r;
    code_nxt  = code_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    pend_nxt  = pend_r;
    added_nxt = added_r;
    tbl_we    = 1'b0;
    tbl_wa    = id_r;
    tbl_wd    = ABSENT;
    lst_we    = 1'b0;
    lst_wa    = count_r[AW-1:0];
    lst_wd    = id_r;
    lst_ra    = cnt_dec[AW-1:0];
    pos_we    = 1'b0;
    pos_wa    = id_r;
    pos_wd    = count_r[AW-1:0];
    unique case (state_r)
      ST_CLR: begin
        tbl_we  = 1'b1;
        tbl_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_id[AW-1:0];
          vid_nxt   = {1'b0, in_id} < ID_LIMIT;
          code_nxt  = in_code;
          added_nxt = '0;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          unique case (in_cmd)
            CMD_LOGIN, CMD_LOGOUT, CMD_QUERY: state_nxt = ST_LOOK;
            CMD_CLOSE: state_nxt = ST_CLOSE;
            CMD_COUNT: begin
              added_nxt = {{(ADDED_W-CW){1'b0}}, count_r};
              state_nxt = ST_RES;
            end
            default: state_nxt = ST_RES;
          endcase
        end
      end
      ST_LOOK: begin
        state_nxt = ST_RES;
        unique case (cmd_r)
          CMD_LOGIN: begin
            if (vid_r) begin
              tbl_we = 1'b1;
              tbl_wd = {1'b0, code_r};
              if (!present) begin
                lst_we    = 1'b1;
                pos_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
          end
          CMD_LOGOUT: begin
            if (vid_r && present) begin
              tbl_we    = 1'b1;
              lst_we    = 1'b1;
              lst_wa    = pos_q;
              lst_wd    = lst_q;
              pos_we    = 1'b1;
              pos_wa    = lst_q;
              pos_wd    = pos_q;
              count_nxt = cnt_dec;
            end
          end
          default: begin
            added_nxt = vid_r ? tbl_q : ABSENT;
          end
        endcase
      end
      ST_CLOSE: begin
        if (scan_r != count_r) begin
          lst_ra   = scan_r[AW-1:0];
          scan_nxt = scan_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          tbl_we = 1'b1;
          tbl_wa = lst_q;
        end
        if (scan_r == count_r && !pend_r) begin
          count_nxt = '0;
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q <= tbl_mem[in_id[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lst_we) begin
      lst_mem[lst_wa] <= lst_wd;
    end
    lst_q <= lst_mem[lst_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_q <= pos_mem[in_id[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      count_r <= '0;
      scan_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    vid_r   <= vid_nxt;
    code_r  <= code_nxt;
    added_r <= added_nxt;
  end

endmodule

// ===== design/keyed_session_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_session_table_top: keyed table of session codes with a running sum
// Login, logout and query pass through a table lookup state before the result
// beat; count and unknown commands go straight to it; close walks the
// present-id list through its single read port, clearing each listed
// entry. One item at a time.
// After reset the table is swept to absent, one entry a cycle, through all
// min(ENTRIES, 1024) entries before the first input beat is accepted.
// ----------------------------------------------------------------------------
module keyed_session_table_top #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command [2:0], id [12:3], code [43:13], zero [47:44]
  input  logic [kst_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // added [31:0], running_sum [95:32]
  output logic [kst_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import kst_pkg::*;

  kst_res_t res;
  logic     res_ready;

  kst_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .res       (res),
    .res_ready (res_ready)
  );

  kst_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyed session table
// Drives login, logout, close, count, query and unused commands over the
// input stream with bursty gaps, stalls the result stream, and checks
// every result beat against a model of the code table, present count and sum.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 32;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;
  localparam logic [ID_W-1:0]  ID_MAX           = ID_W'(ID_SPACE - 1);

  typedef struct packed {
    logic [ADDED_W-1:0] added;
    logic [SUM_W-1:0]   total;
  } session_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [ADDED_W-1:0] session_code [ID_SPACE];
  int unsigned        present_count;
  logic [SUM_W-1:0]   sum_acc;
  session_result_t    awaited_results [$];

  int unsigned     mismatches;
  int unsigned     burst_left;
  logic [31:0]     cycle_count;
  logic [1:0]      stall_mode;
  session_result_t head_result;

  keyed_session_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  initial begin
    out_tready  = 1'b0;
    stall_mode  = 2'd0;
    cycle_count = '0;
    forever begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
      if (cycle_count[5:0] == 6'd0) begin
        stall_mode = 2'($urandom_range(0, 3));
      end
      case (stall_mode)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (cycle_count[2:0] != 3'd0);
      endcase
    end
  end

  function automatic session_result_t compute_session_result(logic [CMD_W-1:0] cmd,
                                                             logic [ID_W-1:0] id,
                                                             logic [CODE_W-1:0] code);
    session_result_t r;
    r.added = '0;
    case (cmd)
      CMD_LOGIN: begin
        if (session_code[id] == ABSENT) present_count++;
        session_code[id] = {1'b0, code};
      end
      CMD_LOGOUT: begin
        if (session_code[id] != ABSENT) begin
          session_code[id] = ABSENT;
          present_count--;
        end
      end
      CMD_CLOSE: begin
        foreach (session_code[k]) session_code[k] = ABSENT;
        present_count = 0;
      end
      CMD_COUNT: r.added = present_count;
      CMD_QUERY: r.added = session_code[id];
      default: ;
    endcase
    sum_acc = sum_acc + {{(SUM_W-ADDED_W){r.added[ADDED_W-1]}}, r.added};
    r.total = sum_acc;
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CODE_W'($urandom());
  endfunction

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic [CODE_W-1:0] code);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-CODE_W-ID_W-CMD_W){1'b0}}, code, id, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_results.push_back(compute_session_result(cmd, id, code));
    burst_left--;
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s mismatch: expected %0d, got %0d", field, $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: added %0d, sum %0d",
                   $signed(out_tdata[ADDED_W-1:0]), $signed(out_tdata[OUT_DATA_W-1:ADDED_W]));
        end
      end else begin
        head_result = awaited_results.pop_front();
        if (out_tdata[ADDED_W-1:0] !== head_result.added) begin
          note_mismatch("added", {{(SUM_W-ADDED_W){head_result.added[ADDED_W-1]}},
                        head_result.added},
                        {{(SUM_W-ADDED_W){out_tdata[ADDED_W-1]}}, out_tdata[ADDED_W-1:0]});
        end
        if (out_tdata[OUT_DATA_W-1:ADDED_W] !== head_result.total) begin
          note_mismatch("running_sum", head_result.total, out_tdata[OUT_DATA_W-1:ADDED_W]);
        end
      end
    end
  end

  task automatic run_directed_cases();
    send_command(CMD_QUERY, '0, random_code());
    send_command(CMD_QUERY, ID_MAX, '0);
    send_command(CMD_COUNT, ID_MAX, '1);
    send_command(CMD_LOGIN, '0, '0);
    send_command(CMD_LOGIN, ID_MAX, '1);
    send_command(CMD_QUERY, '0, '0);
    send_command(CMD_QUERY, ID_MAX, '0);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_LOGIN, '0, 31'h5555_5555);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_QUERY, '0, '0);
    send_command(CMD_LOGOUT, ID_W'(512), '1);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_LOGOUT, ID_MAX, '0);
    send_command(CMD_QUERY, ID_MAX, '0);
    send_command(CMD_COUNT, '0, '0);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) begin
      send_command(CMD_W'(c), ID_W'($urandom_range(0, ID_SPACE-1)), random_code());
    end
    send_command(CMD_CLOSE, '0, '0);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_QUERY, '0, '0);
    send_command(CMD_LOGIN, '0, 31'h2AAA_AAAA);
    send_command(CMD_QUERY, '0, '0);
  endtask

  task automatic run_full_table();
    int unsigned order [ID_SPACE];
    int unsigned j;
    int unsigned swap_id;
    for (int i = 0; i < ID_SPACE; i++) order[i] = i;
    for (int i = ID_SPACE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap_id  = order[i];
      order[i] = order[j];
      order[j] = swap_id;
    end
    foreach (order[i]) send_command(CMD_LOGIN, ID_W'(order[i]), random_code());
    send_command(CMD_COUNT, '0, '0);
    repeat (4) send_command(CMD_QUERY, ID_W'($urandom_range(0, ID_SPACE-1)), '0);
    send_command(CMD_LOGIN, ID_W'(order[0]), random_code());
    send_command(CMD_QUERY, ID_W'(order[0]), '0);
    send_command(CMD_LOGOUT, ID_W'(order[1]), '0);
    send_command(CMD_LOGOUT, ID_W'(order[1]), '0);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_CLOSE, '0, '0);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_QUERY, ID_W'(order[2]), '0);
  endtask

  task automatic run_session_traffic();
    int unsigned pool_log;
    int unsigned pool;
    int unsigned base;
    int unsigned pick;
    logic [ID_W-1:0] id;
    for (int seg = 0; seg < 10; seg++) begin
      pool_log = $urandom_range(0, ID_W);
      pool = 1 << pool_log;
      base = $urandom_range(0, ID_SPACE - pool);
      for (int k = 0; k < 50; k++) begin
        id   = ID_W'(base + $urandom_range(0, pool - 1));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_command(CMD_LOGIN, id, random_code());
        end else if (pick < 50) begin
          send_command(CMD_LOGOUT, id, random_code());
        end else if (pick < 78) begin
          send_command(CMD_QUERY, id, random_code());
        end else if (pick < 88) begin
          send_command(CMD_COUNT, id, random_code());
        end else if (pick < 92) begin
          send_command(CMD_CLOSE, id, random_code());
        end else begin
          send_command(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                       ID_W'($urandom_range(0, ID_SPACE-1)), random_code());
        end
      end
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    mismatches    = 0;
    burst_left    = 0;
    present_count = 0;
    sum_acc       = '0;
    foreach (session_code[k]) session_code[k] = ABSENT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_directed_cases();
    wait_results_drained();
    run_full_table();
    wait_results_drained();
    run_session_traffic();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
